[sv/glu_pkg.sv]
// Shared types, constants and tables for the Gregorian to lunar date converter.
// Holds the lunar year ROM, the date helper functions and the sequencer state type.
// No dependencies.
`default_nettype none

package glu_pkg;

	localparam int ROM_DEPTH       = 201;
	localparam int ROM_IDX_W       = 8;
	localparam int TABLE_YEARS_DEF = 201;
	localparam int ACC_W           = 18;

	// days from 1600-03-01 to 1900-01-31
	localparam logic [ACC_W-1:0] BASE_DAYS = 18'd109543;
	localparam logic [11:0]      YEAR_MIN  = 12'd1900;
	localparam logic [11:0]      YEAR_MAX  = 12'd2100;
	localparam logic [11:0]      YEAR_REF  = 12'd1600;
	localparam logic [3:0]       MONTH_MAX = 4'd12;

	typedef struct packed {
		logic [11:0] greg_year;
		logic [3:0]  greg_month;
		logic [4:0]  greg_day;
	} glu_in_t;

	typedef struct packed {
		logic        date_valid;
		logic [11:0] lun_year;
		logic [3:0]  lun_month;
		logic [4:0]  lunar_day;
		logic        leap_flag;
	} glu_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_BASE,
		ST_YEAR,
		ST_MONTH,
		ST_FIN
	} glu_state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} glu_alu_op_t;

	typedef struct packed {
		glu_alu_op_t      op;
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
	} glu_alu_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] res;
		logic             borrow;
	} glu_alu_rsp_t;

	localparam logic [16:0] LUNAR_ROM [ROM_DEPTH] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
		17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
		17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
		17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
		17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h16a95, 17'h05ad0,
		17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
		17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
		17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
		17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
		17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
		17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
		17'h0b540, 17'h0b6a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
		17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
		17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h05ac0, 17'h0ab60,
		17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
		17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
		17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
		17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
		17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
		17'h04afb, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
		17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
		17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370, 17'h049f8, 17'h04970,
		17'h064b0, 17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0, 17'h092e0,
		17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
		17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6,
		17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930,
		17'h07337, 17'h06aa0, 17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4,
		17'h0d160, 17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0,
		17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252, 17'h0d520
	};

	function automatic logic [4:0] leap_len(input logic [16:0] w);
		logic [4:0] len;
		if (w[3:0] == 4'd0)
			len = 5'd0;
		else
			len = w[16] ? 5'd30 : 5'd29;
		return len;
	endfunction

	function automatic logic [8:0] year_len(input logic [16:0] w);
		logic [8:0] days;
		days = 9'd348;
		for (int i = 4; i < 16; i++)
			days = days + {8'd0, w[i]};
		return days + {4'd0, leap_len(w)};
	endfunction

	function automatic logic [4:0] greg_month_len(input logic [3:0] m, input logic leap_yr);
		logic [4:0] len;
		unique case (m)
			4'd2:                      len = leap_yr ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days from March 1 to the first of the month, March-based month index
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] days;
		unique case (mp)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd61;
			4'd3:    days = 9'd92;
			4'd4:    days = 9'd122;
			4'd5:    days = 9'd153;
			4'd6:    days = 9'd184;
			4'd7:    days = 9'd214;
			4'd8:    days = 9'd245;
			4'd9:    days = 9'd275;
			4'd10:   days = 9'd306;
			4'd11:   days = 9'd337;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

`default_nettype wire

[sv/glu_alu.sv]
// Shared add/subtract unit of the lunar date sequencer.
// Every day-count sum, base offset and year or month length step runs through it.
// Depends on glu_pkg.
`default_nettype none

module glu_alu (
	input  glu_pkg::glu_alu_req_t req,
	output glu_pkg::glu_alu_rsp_t rsp
);
	import glu_pkg::*;

	logic [ACC_W:0] wide;

	always_comb begin
		unique case (req.op)
			ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
			default: wide = '0;
		endcase
		rsp.res    = wide[ACC_W-1:0];
		rsp.borrow = (req.op == ALU_SUB) && wide[ACC_W];
	end

endmodule

`default_nettype wire

[sv/gregorian_to_lunar_date_top.sv]
// Gregorian to Chinese lunar date converter, top level with sequencer and output register.
// Depends on glu_pkg and glu_alu.
//
// One item takes a Gregorian date and returns one lunar date item. The block takes
// an item only while its sequencer is idle; after acceptance the sequencer checks the date,
// sums the day count, subtracts the base offset and then subtracts whole lunar years
// and whole lunar months from the day count, all on the single add/subtract unit that
// steps through the year ROM and then the months. The next item is taken once the
// result has gone to the output register. A finished item sits in the output register
// until taken, and the sequencer holds its next result while that register is full.
// Invalid dates, dates before 1900-01-31 and dates past the last table
// year give date_valid low with all other fields zero.
`default_nettype none

module gregorian_to_lunar_date_top #(
	parameter int TABLE_YEARS = glu_pkg::TABLE_YEARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              greg_valid,
	output logic              greg_ready,
	input  glu_pkg::glu_in_t  greg_date,
	output logic              lunar_valid,
	input  logic              lunar_ready,
	output glu_pkg::glu_out_t lunar_date
);
	import glu_pkg::*;

	localparam int IDX_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_YEARS - 1);

	glu_state_t   state_q, state_d;
	glu_in_t      in_q;
	glu_out_t     out_q;
	logic         out_valid_q;
	logic [ACC_W-1:0] prod_q;
	logic [9:0]   aux_q;
	logic [ACC_W-1:0] acc_q;
	logic [IDX_W-1:0] idx_q;
	logic [16:0]  word_q;
	logic [3:0]   mon_q;
	logic         leap_q;
	logic         ok_q;

	glu_alu_req_t alu_req;
	glu_alu_rsp_t alu_rsp;

	logic         early;
	logic         leap_yr;
	logic         date_ok;
	logic [8:0]   yrel;
	logic [3:0]   mp;
	logic [2:0]   cent;
	logic [9:0]   aux_d;
	logic [16:0]  rom_word;
	logic [8:0]   ylen;
	logic [4:0]   bit_idx;
	logic [4:0]   mlen;
	logic         slot_free;

	glu_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	always_comb begin
		early   = (in_q.greg_month <= 4'd2);
		leap_yr = (in_q.greg_year[1:0] == 2'd0) && (in_q.greg_year != YEAR_MIN)
			&& (in_q.greg_year != YEAR_MAX);
		date_ok = (in_q.greg_year >= YEAR_MIN) && (in_q.greg_year <= YEAR_MAX)
			&& (in_q.greg_month >= 4'd1) && (in_q.greg_month <= MONTH_MAX)
			&& (in_q.greg_day >= 5'd1)
			&& (in_q.greg_day <= greg_month_len(in_q.greg_month, leap_yr));
		yrel    = 9'(in_q.greg_year - YEAR_REF - {11'd0, early});
		mp      = early ? 4'(in_q.greg_month + 4'd9) : 4'(in_q.greg_month - 4'd3);
		cent    = {2'd0, yrel >= 9'd100} + {2'd0, yrel >= 9'd200} + {2'd0, yrel >= 9'd300}
			+ {2'd0, yrel >= 9'd400} + {2'd0, yrel >= 9'd500};
		aux_d   = {3'd0, yrel[8:2]} - {7'd0, cent} + {9'd0, yrel >= 9'd400}
			+ {1'd0, month_start(mp)} + {5'd0, in_q.greg_day} - 10'd1;
		rom_word = LUNAR_ROM[ROM_IDX_W'(idx_q)];
		ylen     = year_len(rom_word);
		bit_idx  = 5'd16 - {1'b0, mon_q};
		mlen     = leap_q ? leap_len(word_q) : (word_q[bit_idx] ? 5'd30 : 5'd29);
		slot_free = !out_valid_q || lunar_ready;
	end

	always_comb begin
		state_d     = state_q;
		greg_ready  = 1'b0;
		alu_req.op  = ALU_ADD;
		alu_req.a   = '0;
		alu_req.b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				greg_ready = 1'b1;
				if (greg_valid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = date_ok ? ST_SUM : ST_FIN;
			end
			ST_SUM: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = prod_q;
				alu_req.b  = ACC_W'(aux_q);
				state_d    = ST_BASE;
			end
			ST_BASE: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = BASE_DAYS;
				state_d    = alu_rsp.borrow ? ST_FIN : ST_YEAR;
			end
			ST_YEAR: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = ACC_W'(ylen);
				if (alu_rsp.borrow)
					state_d = ST_MONTH;
				else if (idx_q == IDX_LAST)
					state_d = ST_FIN;
			end
			ST_MONTH: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = ACC_W'(mlen);
				if (mon_q > MONTH_MAX || alu_rsp.borrow)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (greg_valid)
					in_q <= greg_date;
			end
			ST_CHECK: begin
				ok_q   <= 1'b0;
				prod_q <= ACC_W'({9'd0, yrel} * 18'd365);
				aux_q  <= aux_d;
			end
			ST_SUM: begin
				acc_q <= alu_rsp.res;
			end
			ST_BASE: begin
				acc_q <= alu_rsp.res;
				idx_q <= '0;
			end
			ST_YEAR: begin
				if (alu_rsp.borrow) begin
					word_q <= rom_word;
					mon_q  <= 4'd1;
					leap_q <= 1'b0;
				end else begin
					acc_q <= alu_rsp.res;
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_MONTH: begin
				if (mon_q > MONTH_MAX) begin
					ok_q <= 1'b0;
				end else if (alu_rsp.borrow) begin
					ok_q <= 1'b1;
				end else begin
					acc_q <= alu_rsp.res;
					if (word_q[3:0] == mon_q && !leap_q) begin
						leap_q <= 1'b1;
					end else begin
						leap_q <= 1'b0;
						mon_q  <= mon_q + 4'd1;
					end
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					if (ok_q) begin
						out_q.date_valid <= 1'b1;
						out_q.lun_year   <= YEAR_MIN + 12'(idx_q);
						out_q.lun_month  <= mon_q;
						out_q.lunar_day  <= 5'(acc_q + 18'd1);
						out_q.leap_flag  <= leap_q;
					end else begin
						out_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_FIN && slot_free)
			out_valid_q <= 1'b1;
		else if (lunar_ready)
			out_valid_q <= 1'b0;
	end

	assign lunar_valid = out_valid_q;
	assign lunar_date  = out_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		lunar_valid && !lunar_date.date_valid |->
			lunar_date.lun_year == 12'd0 && lunar_date.lun_month == 4'd0
			&& lunar_date.lunar_day == 5'd0 && !lunar_date.leap_flag)
		else $error("invalid item carries nonzero fields");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		lunar_valid && lunar_date.date_valid |->
			lunar_date.lun_month >= 4'd1 && lunar_date.lun_month <= MONTH_MAX
			&& lunar_date.lunar_day >= 5'd1 && lunar_date.lunar_day <= 5'd30
			&& lunar_date.lun_year >= YEAR_MIN)
		else $error("lunar item out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		greg_valid && greg_ready |=> !greg_ready)
		else $error("item accepted while conversion pending");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		lunar_valid && !lunar_ready |=> $stable(lunar_date))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

[dv/glu_date_checker.sv]
// Checker for the Gregorian to lunar date converter: predicts each lunar date item
// from the accepted Gregorian item and compares it field by field with the output.
// Depends on glu_pkg for the item types and the lunar year ROM.
`timescale 1ns / 1ps

module glu_date_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              greg_valid,
	input  logic              greg_ready,
	input  glu_pkg::glu_in_t  greg_date,
	input  logic              lunar_valid,
	input  logic              lunar_ready,
	input  glu_pkg::glu_out_t lunar_date,
	output int                errors,
	output int                pending
);
	import glu_pkg::*;

	localparam int YEARS = TABLE_YEARS_DEF;

	typedef struct {
		glu_in_t  date;
		glu_out_t lunar;
	} lunar_due_t;

	lunar_due_t lunar_due[$];
	int mismatch_count = 0;
	int due_count = 0;

	assign errors  = mismatch_count;
	assign pending = due_count;

	function automatic int unsigned civil_day_number(input int unsigned y,
			input int unsigned m, input int unsigned d);
		int unsigned yy, q, r, mp;
		yy = (m <= 2) ? y - 1 : y;
		q  = yy / 400;
		r  = yy % 400;
		mp = (m > 2) ? m - 3 : m + 9;
		return q * 146097 + r * 365 + r / 4 - r / 100 + (153 * mp + 2) / 5 + d - 1;
	endfunction

	function automatic int unsigned intercalary_days(input logic [16:0] w);
		if (w[3:0] == 4'd0)
			return 0;
		return w[16] ? 30 : 29;
	endfunction

	function automatic glu_out_t lunar_of_gregorian(input glu_in_t g);
		glu_out_t    r;
		int unsigned y, m, d, month_days, off, span, yr, mon;
		logic [16:0] w;
		bit          in_leap;
		r = '0;
		y = g.greg_year;
		m = g.greg_month;
		d = g.greg_day;
		if (y < 1900 || y > 2100 || m < 1 || m > 12 || d < 1)
			return r;
		case (m)
			2:           month_days = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
			4, 6, 9, 11: month_days = 30;
			default:     month_days = 31;
		endcase
		if (d > month_days)
			return r;
		off  = civil_day_number(y, m, d);
		span = civil_day_number(1900, 1, 31);
		if (off < span)
			return r;
		off = off - span;
		yr = 0;
		w = LUNAR_ROM[0];
		while (yr < YEARS) begin
			w = LUNAR_ROM[yr];
			span = 348 + $countones(w[15:4]) + intercalary_days(w);
			if (off < span)
				break;
			off = off - span;
			yr++;
		end
		if (yr >= YEARS)
			return r;
		in_leap = 1'b0;
		mon = 1;
		while (mon <= 12) begin
			span = in_leap ? intercalary_days(w) : (w[16 - mon] ? 30 : 29);
			if (off < span)
				break;
			off = off - span;
			if (w[3:0] == mon && !in_leap) begin
				in_leap = 1'b1;
			end else begin
				in_leap = 1'b0;
				mon++;
			end
		end
		if (mon > 12)
			return r;
		r.date_valid = 1'b1;
		r.lun_year   = 12'(1900 + yr);
		r.lun_month  = 4'(mon);
		r.lunar_day  = 5'(off + 1);
		r.leap_flag  = in_leap;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		lunar_due_t due;
		lunar_due_t fresh;
		glu_out_t   got;
		string      src;
		if (arst_n) begin
			if (lunar_valid && lunar_ready) begin
				got = lunar_date;
				if (lunar_due.size() == 0) begin
					report_mismatch($sformatf("unexpected item valid=%0d %0d-%0d-%0d leap=%0d",
						got.date_valid, got.lun_year, got.lun_month, got.lunar_day,
						got.leap_flag));
				end else begin
					due = lunar_due.pop_front();
					src = $sformatf("%0d-%0d-%0d", due.date.greg_year, due.date.greg_month,
						due.date.greg_day);
					if (got.date_valid !== due.lunar.date_valid)
						report_mismatch($sformatf("%s date_valid got %0d want %0d", src,
							got.date_valid, due.lunar.date_valid));
					if (got.lun_year !== due.lunar.lun_year)
						report_mismatch($sformatf("%s lun_year got %0d want %0d", src,
							got.lun_year, due.lunar.lun_year));
					if (got.lun_month !== due.lunar.lun_month)
						report_mismatch($sformatf("%s lun_month got %0d want %0d", src,
							got.lun_month, due.lunar.lun_month));
					if (got.lunar_day !== due.lunar.lunar_day)
						report_mismatch($sformatf("%s lunar_day got %0d want %0d", src,
							got.lunar_day, due.lunar.lunar_day));
					if (got.leap_flag !== due.lunar.leap_flag)
						report_mismatch($sformatf("%s leap_flag got %0d want %0d", src,
							got.leap_flag, due.lunar.leap_flag));
				end
			end
			if (greg_valid && greg_ready) begin
				fresh.date  = greg_date;
				fresh.lunar = lunar_of_gregorian(greg_date);
				lunar_due.push_back(fresh);
			end
		end
		due_count = lunar_due.size();
	end

endmodule

[dv/tb_gregorian_to_lunar_date_top.sv]
// Testbench top for the Gregorian to lunar date converter: drives directed and random
// dates with bursty input and a stalling receiver, and gives the verdict.
// Depends on glu_pkg, gregorian_to_lunar_date_top and glu_date_checker.
`timescale 1ns / 1ps

module tb_gregorian_to_lunar_date_top;
	import glu_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int RANDOM_DATES = 2000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     greg_valid = 1'b0;
	logic     greg_ready;
	glu_in_t  greg_date = '0;
	logic     lunar_valid;
	logic     lunar_ready = 1'b0;
	glu_out_t lunar_date;

	int errors;
	int pending;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	always #2 clk = ~clk;

	gregorian_to_lunar_date_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.greg_valid (greg_valid),
		.greg_ready (greg_ready),
		.greg_date  (greg_date),
		.lunar_valid(lunar_valid),
		.lunar_ready(lunar_ready),
		.lunar_date (lunar_date)
	);

	glu_date_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.greg_valid (greg_valid),
		.greg_ready (greg_ready),
		.greg_date  (greg_date),
		.lunar_valid(lunar_valid),
		.lunar_ready(lunar_ready),
		.lunar_date (lunar_date),
		.errors     (errors),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: switch between free flow, random, mostly stalled and periodic
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(50, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0:       lunar_ready <= 1'b1;
			1:       lunar_ready <= 1'($urandom_range(0, 1));
			2:       lunar_ready <= ($urandom_range(0, 7) == 0);
			default: lunar_ready <= (cycles % 5 < 2);
		endcase
	end

	task automatic send_date(input glu_in_t d);
		int gap;
		bit took;
		if (burst_left == 0) begin
			case ($urandom_range(0, 7))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(40, 300);
				default: gap = $urandom_range(1, 40);
			endcase
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				greg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		greg_valid <= 1'b1;
		greg_date  <= d;
		do begin
			@(negedge clk);
			took = greg_ready;
			@(posedge clk);
		end while (!took);
	endtask

	function automatic glu_in_t random_date();
		glu_in_t     g;
		int unsigned pick, last;
		pick = $urandom_range(0, 99);
		g.greg_year  = 12'($urandom_range(1900, 2100));
		if (pick < 6)
			g.greg_year = 12'd1900;
		else if (pick < 10)
			g.greg_year = 12'd2100;
		g.greg_month = 4'($urandom_range(1, 12));
		if (pick < 3)
			g.greg_month = 4'd1;
		else if (pick >= 6 && pick < 9)
			g.greg_month = 4'd12;
		case (g.greg_month)
			4'd2: last = ((g.greg_year % 4 == 0 && g.greg_year % 100 != 0) ||
				g.greg_year % 400 == 0) ? 29 : 28;
			4'd4, 4'd6, 4'd9, 4'd11: last = 30;
			default: last = 31;
		endcase
		g.greg_day = 5'($urandom_range(1, last));
		if (pick >= 10 && pick < 18)
			g.greg_day = 5'(last);
		else if (pick >= 18 && pick < 22)
			g.greg_day = 5'd1;
		else if (pick >= 22 && pick < 30)
			g = 21'($urandom);
		else if (pick >= 30 && pick < 38) begin
			g.greg_month = 4'($urandom_range(0, 15));
			g.greg_day   = 5'($urandom_range(0, 31));
		end
		return g;
	endfunction

	initial begin
		glu_in_t directed[$] = '{
			{12'd1900, 4'd1, 5'd31}, {12'd1900, 4'd1, 5'd30}, {12'd1900, 4'd1, 5'd1},
			{12'd1900, 4'd2, 5'd1}, {12'd2100, 4'd12, 5'd31}, {12'd2100, 4'd1, 5'd1},
			{12'd2101, 4'd1, 5'd1}, {12'd1899, 4'd12, 5'd31}, {12'd0, 4'd0, 5'd0},
			{12'd4095, 4'd15, 5'd31}, {12'd2000, 4'd13, 5'd10}, {12'd2000, 4'd0, 5'd10},
			{12'd2000, 4'd4, 5'd31}, {12'd2000, 4'd4, 5'd0}, {12'd2000, 4'd2, 5'd29},
			{12'd1900, 4'd2, 5'd29}, {12'd2023, 4'd2, 5'd29}, {12'd2024, 4'd2, 5'd29},
			{12'd2000, 4'd2, 5'd30}, {12'd2023, 4'd3, 5'd22}, {12'd2020, 4'd6, 5'd20},
			{12'd2024, 4'd2, 5'd10}, {12'd2033, 4'd12, 5'd22}, {12'd1984, 4'd12, 5'd31}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_date(directed[i]);
		repeat (RANDOM_DATES)
			send_date(random_date());
		greg_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
